### hdl/tpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and codes of the two-phase commit coordinator
// Transaction structs, operation and result codes, scoreboard codes, defaults.
// ----------------------------------------------------------------------------
package tpc_pkg;

	localparam int CLIENTS_DEFAULT = 16;
	localparam int CLIENT_W        = 4;
	localparam int RETX_W          = 6;
	localparam int CLIENTS_CFG_W   = 5;
	localparam int TIMEOUT_W       = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int SB_W            = 3;

	localparam logic [RETX_W-1:0]           RETRANSMIT_DEFAULT = 6'd20;
	localparam logic [TIMEOUT_W-1:0]        TIMEOUT_DEFAULT    = 32'hFFFF_FFFF;

	localparam logic [CFG_IDX_W-1:0] REG_CLIENTS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_RETX = 2'd2;

	localparam logic [1:0] OP_START   = 2'd0;
	localparam logic [1:0] OP_SEND    = 2'd1;
	localparam logic [1:0] OP_MESSAGE = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	localparam logic [1:0] SEND_DELIVERED = 2'd0;
	localparam logic [1:0] SEND_TIMEOUT   = 2'd2;

	localparam logic [1:0] KIND_REQUEST = 2'd0;
	localparam logic [1:0] KIND_COMMIT  = 2'd1;
	localparam logic [1:0] KIND_CANCEL  = 2'd2;
	localparam logic [1:0] KIND_OUTCOME = 2'd3;

	localparam logic [1:0] OUT_SUCCESS = 2'd0;
	localparam logic [1:0] OUT_FAIL    = 2'd1;
	localparam logic [1:0] OUT_CLUSTER = 2'd2;

	localparam logic [SB_W-1:0] SB_LOST = 3'd0;
	localparam logic [SB_W-1:0] SB_YES  = 3'd1;
	localparam logic [SB_W-1:0] SB_NO   = 3'd2;
	localparam logic [SB_W-1:0] SB_ACK  = 3'd3;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ONE  = 2'd1;
	localparam logic [1:0] PH_TWO  = 2'd2;

	localparam logic [2:0] CMD_START     = 3'd0;
	localparam logic [2:0] CMD_DELIVERED = 3'd1;
	localparam logic [2:0] CMD_RETX      = 3'd2;
	localparam logic [2:0] CMD_MSG       = 3'd3;
	localparam logic [2:0] CMD_TICK      = 3'd4;

	typedef struct packed {
		logic [1:0]          operation;
		logic [CLIENT_W-1:0] client;
		logic [1:0]          message_code;
		logic [1:0]          send_status;
	} item_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [1:0]          outcome;
		logic [CLIENT_W-1:0] failed_client;
	} result_t;

	typedef struct packed {
		logic [2:0]          kind;
		logic [CLIENT_W-1:0] client;
		logic [1:0]          code;
	} cmd_t;

endpackage
`default_nettype wire

### hdl/two_phase_commit_coordinator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_phase_commit_coordinator: coordinator of one two-phase commit round
// Front classifies item transactions into a short queue; back runs the
// round state, scans the scoreboard at phase ends and drives the results.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   item     | item_valid / item_stall    | item   (operation, client, ...)
//   result   | result_valid / result_stall| result (kind, outcome, client)
//   config   | cfg_write                  | cfg_index, cfg_data
//
// In the back an ordinary item is dequeued with a counter RAM read, then
// applied in the update. A phase end adds the scoreboard scan, one entry
// per cycle through the scoreboard RAM read port, then the drain and finish.
// Reset leaves the block idle with the default registers; per-entry valid
// bits stand for a cleared scoreboard, so no clearing pass is needed.
// A stalled result holds the back only when it has another result to give.
// ----------------------------------------------------------------------------
module two_phase_commit_coordinator
	import tpc_pkg::*;
#(
	parameter int MAX_CLIENTS = CLIENTS_DEFAULT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_stall,
	input  wire item_t                 item,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_write,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_CLIENTS + 1);
	localparam int IDX_W = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;

	logic [CLIENTS_CFG_W-1:0] clients_q;
	logic [TIMEOUT_W-1:0]     timeout_q;
	logic [RETX_W-1:0]        max_retx_q;
	logic [CNT_W-1:0]         n_active;
	logic                     push;
	cmd_t                     push_cmd;
	logic                     pop;
	cmd_t                     head;
	logic                     q_empty;
	logic                     q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clients_q  <= CLIENTS_CFG_W'(CLIENTS_DEFAULT);
			timeout_q  <= TIMEOUT_DEFAULT;
			max_retx_q <= RETRANSMIT_DEFAULT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_CLIENTS:  clients_q  <= cfg_data[CLIENTS_CFG_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_data[TIMEOUT_W-1:0];
				REG_MAX_RETX: max_retx_q <= cfg_data[RETX_W-1:0];
				default:      max_retx_q <= max_retx_q;
			endcase
		end
	end

	always_comb begin
		if (clients_q == '0) begin
			n_active = CNT_W'(1);
		end else if (int'(clients_q) > MAX_CLIENTS) begin
			n_active = CNT_W'(MAX_CLIENTS);
		end else begin
			n_active = CNT_W'(clients_q);
		end
	end

	tpc_front #(.CNT_W(CNT_W)) u_front (
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.n_active   (n_active),
		.q_full     (q_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	tpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	tpc_back #(
		.MAX_CLIENTS (MAX_CLIENTS),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.n_active     (n_active),
		.timeout      (timeout_q),
		.max_retx     (max_retx_q),
		.empty        (q_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_broadcast_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.kind != KIND_OUTCOME) |->
			(result.outcome == OUT_SUCCESS) && (result.failed_client == '0))
		else $error("broadcast result carries outcome or client");

	a_failed_client_cluster: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.failed_client != '0) |->
			(result.kind == KIND_OUTCOME) && (result.outcome == OUT_CLUSTER))
		else $error("failed client named outside cluster failure");

	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("queue popped while empty");
`endif

endmodule
`default_nettype wire

### hdl/tpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tpc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### hdl/tpc_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_queue: command queue between front and back
// Small FIFO of classified commands; lets either side stall on its own.
// ----------------------------------------------------------------------------
module tpc_queue
	import tpc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output logic      empty,
	output logic      full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

### hdl/tpc_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_front: input side of the coordinator
// Accepts item transactions, classifies them and drops those with no effect.
// ----------------------------------------------------------------------------
module tpc_front
	import tpc_pkg::*;
#(
	parameter int CNT_W = 5
) (
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire item_t            item,
	input  wire logic [CNT_W-1:0] n_active,
	input  wire logic             q_full,
	output logic                  push,
	output cmd_t                  push_cmd
);

	localparam int CMP_W = (CNT_W > CLIENT_W) ? CNT_W : CLIENT_W;

	logic keep;
	logic out_of_range;

	assign out_of_range = CMP_W'(item.client) >= CMP_W'(n_active);

	always_comb begin
		keep            = 1'b1;
		push_cmd.kind   = CMD_TICK;
		push_cmd.client = item.client;
		push_cmd.code   = item.message_code;
		case (item.operation)
			OP_START: begin
				push_cmd.kind = CMD_START;
			end
			OP_SEND: begin
				case (item.send_status)
					SEND_DELIVERED: push_cmd.kind = CMD_DELIVERED;
					SEND_TIMEOUT:   push_cmd.kind = CMD_RETX;
					default:        keep = 1'b0;
				endcase
				if (out_of_range) begin
					keep = 1'b0;
				end
			end
			OP_MESSAGE: begin
				push_cmd.kind = CMD_MSG;
				if (out_of_range) begin
					keep = 1'b0;
				end
			end
			OP_TICK: begin
				push_cmd.kind = CMD_TICK;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign item_stall = q_full;
	assign push       = item_valid && !q_full && keep;

endmodule
`default_nettype wire

### hdl/tpc_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_back: execution side of the coordinator
// Applies commands to the round state, scans the scoreboard at phase ends
// and holds the result transaction in an output register.
// ----------------------------------------------------------------------------
module tpc_back
	import tpc_pkg::*;
#(
	parameter int MAX_CLIENTS = CLIENTS_DEFAULT,
	parameter int CNT_W       = $clog2(MAX_CLIENTS + 1),
	parameter int IDX_W       = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [CNT_W-1:0]     n_active,
	input  wire logic [TIMEOUT_W-1:0] timeout,
	input  wire logic [RETX_W-1:0]    max_retx,
	input  wire logic                 empty,
	input  wire cmd_t                 head,
	output logic                      pop,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0]             state_q;
	cmd_t                   cmd_q;
	logic [1:0]             phase_q;
	logic                   fpok_q;
	logic [MAX_CLIENTS-1:0] dmask_q;
	logic [MAX_CLIENTS-1:0] sbv_q;
	logic [MAX_CLIENTS-1:0] rtv_q;
	logic [CNT_W-1:0]       dtotal_q;
	logic [CNT_W-1:0]       vtotal_q;
	logic [TIMEOUT_W-1:0]   elapsed_q;
	logic [IDX_W-1:0]       scan_q;
	logic                   rd_s1;
	logic                   sbv_s1;
	logic                   lost_q;
	logic                   no_q;
	logic                   out_valid_q;
	result_t                out_q;

	logic [IDX_W-1:0]     idx;
	logic [IDX_W-1:0]     rt_raddr;
	logic [RETX_W-1:0]    rt_rdata;
	logic [RETX_W-1:0]    rt_cnt;
	logic [SB_W-1:0]      sb_rdata;
	logic [SB_W-1:0]      sb_entry;
	logic                 active;
	logic                 delivered;
	logic                 skip;
	logic                 mark_d;
	logic                 rt_we;
	logic                 sb_we;
	logic                 retx_fail;
	logic                 timed_out;
	logic                 go;
	logic                 emit_now;
	logic                 out_free;
	logic                 hold;
	logic                 scan_last;
	logic                 pass_one;
	logic [CNT_W-1:0]     dtotal_nx;
	logic [CNT_W-1:0]     vtotal_nx;
	logic [TIMEOUT_W-1:0] elapsed_nx;
	result_t              fin_result;

	assign idx       = IDX_W'(cmd_q.client);
	assign rt_raddr  = (state_q == S_IDLE) ? IDX_W'(head.client) : idx;
	assign pop       = (state_q == S_IDLE) && !empty;
	assign active    = (phase_q != PH_IDLE);
	assign delivered = dmask_q[idx];
	assign skip      = ((cmd_q.kind == CMD_DELIVERED) || (cmd_q.kind == CMD_RETX)) && delivered;
	assign rt_cnt    = rtv_q[idx] ? rt_rdata : '0;
	assign sb_entry  = sbv_s1 ? sb_rdata : SB_LOST;
	assign out_free  = !out_valid_q || !result_stall;
	assign scan_last = (CNT_W'(scan_q) + CNT_W'(1)) == n_active;
	assign pass_one  = (phase_q == PH_ONE) && !lost_q;

	tpc_ram #(.WIDTH(RETX_W), .DEPTH(MAX_CLIENTS)) u_rt_ram (
		.clk   (clk),
		.we    (rt_we),
		.waddr (idx),
		.wdata (rt_cnt + RETX_W'(1)),
		.raddr (rt_raddr),
		.rdata (rt_rdata)
	);

	tpc_ram #(.WIDTH(SB_W), .DEPTH(MAX_CLIENTS)) u_sb_ram (
		.clk   (clk),
		.we    (sb_we),
		.waddr (idx),
		.wdata (SB_W'(cmd_q.code) + SB_W'(1)),
		.raddr (scan_q),
		.rdata (sb_rdata)
	);

	always_comb begin
		dtotal_nx  = dtotal_q;
		vtotal_nx  = vtotal_q;
		elapsed_nx = elapsed_q;
		mark_d     = 1'b0;
		rt_we      = 1'b0;
		sb_we      = 1'b0;
		retx_fail  = 1'b0;
		if (state_q == S_EXEC && active) begin
			case (cmd_q.kind)
				CMD_DELIVERED: begin
					if (!delivered) begin
						dtotal_nx = dtotal_q + CNT_W'(1);
						mark_d    = 1'b1;
					end
				end
				CMD_RETX: begin
					if (!delivered) begin
						if (rt_cnt >= max_retx) begin
							retx_fail = 1'b1;
						end else begin
							rt_we = 1'b1;
						end
					end
				end
				CMD_MSG: begin
					sb_we = 1'b1;
					if (vtotal_q < CNT_W'(MAX_CLIENTS)) begin
						vtotal_nx = vtotal_q + CNT_W'(1);
					end
				end
				CMD_TICK: begin
					if (dtotal_q >= n_active && !timeout[TIMEOUT_W-1] && elapsed_q != '1) begin
						elapsed_nx = elapsed_q + TIMEOUT_W'(1);
					end
				end
				default: begin
					dtotal_nx = dtotal_q;
				end
			endcase
		end
	end

	assign timed_out = !timeout[TIMEOUT_W-1] &&
		(elapsed_nx > {1'b0, timeout[TIMEOUT_W-2:0]});
	assign go = active && (cmd_q.kind != CMD_START) && !retx_fail && !skip &&
		(dtotal_nx >= n_active) && ((vtotal_nx >= n_active) || timed_out);
	assign emit_now = (cmd_q.kind == CMD_START) || retx_fail;
	assign hold     = emit_now && !out_free;

	always_comb begin
		fin_result.failed_client = '0;
		if (phase_q == PH_ONE) begin
			if (lost_q) begin
				fin_result.kind    = KIND_OUTCOME;
				fin_result.outcome = OUT_CLUSTER;
			end else begin
				fin_result.kind    = no_q ? KIND_CANCEL : KIND_COMMIT;
				fin_result.outcome = OUT_SUCCESS;
			end
		end else begin
			fin_result.kind = KIND_OUTCOME;
			if (lost_q) begin
				fin_result.outcome = OUT_CLUSTER;
			end else begin
				fin_result.outcome = fpok_q ? OUT_SUCCESS : OUT_FAIL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_IDLE;
			fpok_q      <= 1'b0;
			dmask_q     <= '0;
			sbv_q       <= '0;
			rtv_q       <= '0;
			dtotal_q    <= '0;
			vtotal_q    <= '0;
			elapsed_q   <= '0;
			scan_q      <= '0;
			rd_s1       <= 1'b0;
			sbv_s1      <= 1'b0;
			lost_q      <= 1'b0;
			no_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			rd_s1 <= 1'b0;
			if (rd_s1) begin
				if (phase_q == PH_ONE) begin
					if (sb_entry == SB_NO) begin
						no_q <= 1'b1;
					end else if (sb_entry != SB_YES) begin
						lost_q <= 1'b1;
					end
				end else if (sb_entry != SB_ACK) begin
					lost_q <= 1'b1;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (!empty) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (!hold) begin
						if (cmd_q.kind == CMD_START) begin
							phase_q     <= PH_ONE;
							dmask_q     <= '0;
							sbv_q       <= '0;
							rtv_q       <= '0;
							dtotal_q    <= '0;
							vtotal_q    <= '0;
							elapsed_q   <= '0;
							out_valid_q <= 1'b1;
						end else begin
							dtotal_q  <= dtotal_nx;
							vtotal_q  <= vtotal_nx;
							elapsed_q <= elapsed_nx;
							if (mark_d) begin
								dmask_q[idx] <= 1'b1;
							end
							if (rt_we) begin
								rtv_q[idx] <= 1'b1;
							end
							if (sb_we) begin
								sbv_q[idx] <= 1'b1;
							end
							if (retx_fail) begin
								phase_q     <= PH_IDLE;
								out_valid_q <= 1'b1;
							end
						end
						lost_q  <= 1'b0;
						no_q    <= 1'b0;
						scan_q  <= '0;
						state_q <= go ? S_SCAN : S_IDLE;
					end
				end
				S_SCAN: begin
					rd_s1  <= 1'b1;
					sbv_s1 <= sbv_q[scan_q];
					scan_q <= scan_q + IDX_W'(1);
					if (scan_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (pass_one) begin
							fpok_q    <= !no_q;
							phase_q   <= PH_TWO;
							dmask_q   <= '0;
							sbv_q     <= '0;
							rtv_q     <= '0;
							dtotal_q  <= '0;
							vtotal_q  <= '0;
							elapsed_q <= '0;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == S_EXEC && !hold && emit_now) begin
			if (cmd_q.kind == CMD_START) begin
				out_q <= '{kind: KIND_REQUEST, outcome: OUT_SUCCESS, failed_client: '0};
			end else begin
				out_q <= '{kind: KIND_OUTCOME, outcome: OUT_CLUSTER,
					failed_client: cmd_q.client};
			end
		end
		if (state_q == S_FIN && out_free) begin
			out_q <= fin_result;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
`default_nettype wire

### dv/two_phase_commit_coordinator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_phase_commit_coordinator_tb: self-checking bench of the commit coordinator
// Feeds start, send-status, message and tick transactions in bursts, mirrors
// every round in a behavioral coordinator and checks each broadcast and
// outcome in order while the result side stalls on a pattern of its own.
// Registers change only between phases, once every reply has come back.
// ----------------------------------------------------------------------------
module two_phase_commit_coordinator_tb
	import tpc_pkg::*;
();

	localparam int NCL          = CLIENTS_DEFAULT;
	localparam int SETTLE       = 64;
	localparam int PHASE_ITEMS  = 135;
	localparam int RAND_PHASES  = 12;
	localparam int REPORT_LIMIT = 40;

	localparam logic [1:0] MSG_YES   = 2'd0;
	localparam logic [1:0] MSG_NO    = 2'd1;
	localparam logic [1:0] MSG_ACK   = 2'd2;
	localparam logic [1:0] MSG_OTHER = 2'd3;

	localparam logic [1:0] SEND_RETRY   = 2'd1;
	localparam logic [1:0] SEND_UNKNOWN = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_BEAT} stall_mode_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	two_phase_commit_coordinator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #1 clk = ~clk;

	item_t   net_events[$];
	result_t due_replies[$];
	int      queued_total = 0;
	int      err_count    = 0;

	logic [4:0] cl_cfg;
	longint     tmo_cfg;
	logic [5:0] retx_max;

	logic [1:0]      rnd_phase;
	bit              first_ok;
	logic [SB_W-1:0] board [NCL];
	logic [5:0]      retx_cnt [NCL];
	bit              sent_ok [NCL];
	int unsigned     sent_total;
	int unsigned     vote_total;
	logic [31:0]     ticks_elapsed;

	function automatic int unsigned live_clients();
		if (cl_cfg == 0) return 1;
		if (cl_cfg > NCL) return NCL;
		return cl_cfg;
	endfunction

	function automatic void clear_round(input logic [1:0] next);
		for (int i = 0; i < NCL; i++) begin
			board[i]    = SB_LOST;
			retx_cnt[i] = '0;
			sent_ok[i]  = 1'b0;
		end
		sent_total    = 0;
		vote_total    = 0;
		ticks_elapsed = '0;
		rnd_phase     = next;
	endfunction

	function automatic bit close_phase(input int unsigned n, output result_t r);
		bit lost;
		bit nay;
		lost = 1'b0;
		nay  = 1'b0;
		r    = '0;
		if (sent_total < n) return 1'b0;
		if (vote_total < n && !(tmo_cfg >= 0 && longint'({32'd0, ticks_elapsed}) > tmo_cfg))
			return 1'b0;
		r.kind = KIND_OUTCOME;
		if (rnd_phase == PH_ONE) begin
			for (int i = 0; i < n; i++) begin
				if (board[i] == SB_NO) nay = 1'b1;
				else if (board[i] != SB_YES) lost = 1'b1;
			end
			if (lost) begin
				rnd_phase = PH_IDLE;
				r.outcome = OUT_CLUSTER;
				return 1'b1;
			end
			first_ok = !nay;
			clear_round(PH_TWO);
			r.kind = nay ? KIND_CANCEL : KIND_COMMIT;
			return 1'b1;
		end
		for (int i = 0; i < n; i++)
			if (board[i] != SB_ACK) lost = 1'b1;
		rnd_phase = PH_IDLE;
		r.outcome = lost ? OUT_CLUSTER : (first_ok ? OUT_SUCCESS : OUT_FAIL);
		return 1'b1;
	endfunction

	function automatic void advance_round(input item_t it);
		result_t     r;
		bit          fire;
		bit          check;
		int unsigned n;
		n     = live_clients();
		fire  = 1'b0;
		check = 1'b1;
		r     = '0;
		if (it.operation == OP_START) begin
			clear_round(PH_ONE);
			r.kind = KIND_REQUEST;
			fire   = 1'b1;
		end else if (rnd_phase != PH_IDLE) begin
			case (it.operation)
				OP_SEND: begin
					if (it.client >= n || sent_ok[it.client]) begin
						check = 1'b0;
					end else if (it.send_status == SEND_DELIVERED) begin
						sent_ok[it.client] = 1'b1;
						sent_total++;
					end else if (it.send_status == SEND_TIMEOUT) begin
						if (retx_cnt[it.client] >= retx_max) begin
							rnd_phase       = PH_IDLE;
							r.kind          = KIND_OUTCOME;
							r.outcome       = OUT_CLUSTER;
							r.failed_client = it.client;
							fire            = 1'b1;
							check           = 1'b0;
						end else begin
							retx_cnt[it.client]++;
						end
					end else begin
						check = 1'b0;
					end
				end
				OP_MESSAGE: begin
					if (it.client >= n) begin
						check = 1'b0;
					end else begin
						board[it.client] = {1'b0, it.message_code} + 3'd1;
						if (vote_total < NCL) vote_total++;
					end
				end
				default: begin
					if (sent_total >= n && tmo_cfg >= 0 && ticks_elapsed != '1)
						ticks_elapsed++;
				end
			endcase
			if (check) fire = close_phase(n, r);
		end
		if (fire) due_replies.push_back(r);
	endfunction

	function automatic logic [1:0] rnd2();
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic logic [3:0] rnd4();
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic item_t mk(input logic [1:0] op, input logic [3:0] cl,
			input logic [1:0] code, input logic [1:0] st);
		item_t it;
		it.operation    = op;
		it.client       = cl;
		it.message_code = code;
		it.send_status  = st;
		return it;
	endfunction

	function automatic void add(input item_t it);
		net_events.push_back(it);
		queued_total++;
	endfunction

	function automatic item_t noise_item();
		logic [1:0] op;
		op = ($urandom_range(0, 9) == 0) ? OP_START : 2'($urandom_range(1, 3));
		return mk(op, rnd4(), rnd2(), rnd2());
	endfunction

	function automatic logic [1:0] pick_vote(input bit second);
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (second) return (roll == 0) ? rnd2() : MSG_ACK;
		if (roll < 15) return MSG_YES;
		if (roll < 19) return MSG_NO;
		return ($urandom_range(0, 1) != 0) ? MSG_OTHER : MSG_ACK;
	endfunction

	function automatic void queue_phase(input int unsigned n, input bit second, input bit lossy);
		item_t       sends[$];
		item_t       votes[$];
		int unsigned tries;
		for (int c = 0; c < n; c++) begin
			if (retx_max <= 6 && $urandom_range(0, 60) == 0)
				tries = retx_max + 1;
			else
				tries = $urandom_range(0, (retx_max < 2) ? retx_max : 2);
			repeat (tries) sends.push_back(mk(OP_SEND, 4'(c), rnd2(), SEND_TIMEOUT));
			if ($urandom_range(0, 5) == 0)
				sends.push_back(mk(OP_SEND, 4'(c), rnd2(), SEND_RETRY));
			sends.push_back(mk(OP_SEND, 4'(c), rnd2(), SEND_DELIVERED));
			if (!lossy || $urandom_range(0, 2) != 0)
				votes.push_back(mk(OP_MESSAGE, 4'(c), pick_vote(second), rnd2()));
			if ($urandom_range(0, 14) == 0)
				votes.push_back(mk(OP_MESSAGE, 4'(c), pick_vote(second), rnd2()));
		end
		while (sends.size() + votes.size() != 0) begin
			if ($urandom_range(0, 9) == 0) add(mk(OP_TICK, rnd4(), rnd2(), rnd2()));
			if ($urandom_range(0, 24) == 0) add(noise_item());
			if (votes.size() == 0 || (sends.size() != 0 && $urandom_range(0, 1) != 0))
				add(sends.pop_front());
			else
				add(votes.pop_front());
		end
		// run the clock out when votes went missing
		if (lossy && tmo_cfg >= 0 && tmo_cfg < 12)
			repeat (int'(tmo_cfg) + 2) add(mk(OP_TICK, rnd4(), rnd2(), rnd2()));
	endfunction

	function automatic void queue_round();
		int unsigned n;
		bit          lossy;
		n     = live_clients();
		lossy = ($urandom_range(0, 3) == 0);
		add(mk(OP_START, rnd4(), rnd2(), rnd2()));
		queue_phase(n, 1'b0, lossy);
		if ($urandom_range(0, 9) != 0) queue_phase(n, 1'b1, lossy);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_CLIENTS:  cl_cfg   = val[4:0];
			REG_TIMEOUT:  tmo_cfg  = longint'($signed(val));
			REG_MAX_RETX: retx_max = val[5:0];
			default: ;
		endcase
	endtask

	task automatic settle();
		@(negedge clk);
		while (net_events.size() != 0 || item_valid || due_replies.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	int burst_left = 0;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				advance_round(item);
			if (!item_valid || !item_stall) begin
				if (gap_left == 0 && net_events.size() != 0) begin
					item       <= net_events.pop_front();
					item_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					item_valid <= 1'b0;
					if (gap_left > 0) gap_left--;
				end
			end
		end
	end

	stall_mode_t stall_mode = STALL_NONE;
	int          cyc        = 0;
	result_t     want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (due_replies.size() == 0) begin
					err_count++;
					if (err_count <= REPORT_LIMIT)
						$display("%0t: unexpected result: expected none, actual kind=%0d outcome=%0d client=%0d",
							$time, result.kind, result.outcome, result.failed_client);
				end else begin
					want = due_replies.pop_front();
					if (result.kind !== want.kind || result.outcome !== want.outcome ||
							result.failed_client !== want.failed_client) begin
						err_count++;
						if (err_count <= REPORT_LIMIT)
							$display("%0t: result mismatch: expected kind=%0d outcome=%0d client=%0d, actual kind=%0d outcome=%0d client=%0d",
								$time, want.kind, want.outcome, want.failed_client,
								result.kind, result.outcome, result.failed_client);
					end
				end
			end
			cyc++;
			if (cyc % 300 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
			case (stall_mode)
				STALL_NONE:  result_stall <= 1'b0;
				STALL_LIGHT: result_stall <= ($urandom_range(0, 2) == 0);
				STALL_HEAVY: result_stall <= ($urandom_range(0, 2) != 0);
				default:     result_stall <= ((cyc % 8) < 5);
			endcase
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] set_clients;
		logic [CFG_DATA_W-1:0] set_timeout;
		logic [CFG_DATA_W-1:0] set_retx;
		int                    phase_end;
		cl_cfg   = 5'(CLIENTS_DEFAULT);
		tmo_cfg  = -1;
		retx_max = RETRANSMIT_DEFAULT;
		first_ok = 1'b0;
		clear_round(PH_IDLE);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(REG_CLIENTS, 32'd2);
		write_reg(REG_TIMEOUT, 32'd3);
		write_reg(REG_MAX_RETX, 32'd0);
		@(negedge clk);
		// drop everything while idle
		add(mk(OP_TICK, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd15, MSG_OTHER, SEND_UNKNOWN));
		add(mk(OP_MESSAGE, 4'd15, MSG_OTHER, SEND_UNKNOWN));
		// first retransmit timeout fails the cluster
		add(mk(OP_START, 4'd15, MSG_OTHER, SEND_UNKNOWN));
		add(mk(OP_SEND, 4'd2, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_RETRY));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_UNKNOWN));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_TIMEOUT));
		// no vote cancels, acks then end in commit fail
		add(mk(OP_START, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_TIMEOUT));
		add(mk(OP_SEND, 4'd1, MSG_YES, SEND_DELIVERED));
		add(mk(OP_MESSAGE, 4'd0, MSG_NO, SEND_DELIVERED));
		add(mk(OP_MESSAGE, 4'd1, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd1, MSG_YES, SEND_DELIVERED));
		add(mk(OP_MESSAGE, 4'd0, MSG_ACK, SEND_DELIVERED));
		add(mk(OP_MESSAGE, 4'd1, MSG_ACK, SEND_DELIVERED));
		// restart mid-round, then time out with a vote missing
		add(mk(OP_START, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_START, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd0, MSG_YES, SEND_DELIVERED));
		add(mk(OP_SEND, 4'd1, MSG_YES, SEND_DELIVERED));
		add(mk(OP_MESSAGE, 4'd0, MSG_YES, SEND_DELIVERED));
		repeat (4) add(mk(OP_TICK, 4'd15, MSG_OTHER, SEND_UNKNOWN));
		settle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: begin set_clients = 1;  set_timeout = 32'hFFFF_FFFF; set_retx = 20; end
				1: begin set_clients = 3;  set_timeout = 0;             set_retx = 1;  end
				2: begin set_clients = 16; set_timeout = 32'hFFFF_FFFF; set_retx = 63; end
				3: begin set_clients = 0;  set_timeout = 5;             set_retx = 2;  end
				4: begin set_clients = 31; set_timeout = 32'h7FFF_FFFF; set_retx = 3;  end
				5: begin set_clients = 4;  set_timeout = 32'h8000_0000; set_retx = 0;  end
				6: begin set_clients = 2;  set_timeout = 1;             set_retx = 63; end
				default: begin
					set_clients = $urandom_range(1, 4);
					set_timeout = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 10);
					set_retx    = $urandom_range(0, 4);
				end
			endcase
			write_reg(REG_CLIENTS, set_clients);
			write_reg(REG_TIMEOUT, set_timeout);
			write_reg(REG_MAX_RETX, set_retx);
			@(negedge clk);
			phase_end = queued_total + PHASE_ITEMS;
			while (queued_total < phase_end) queue_round();
			settle();
		end

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hdl/tpc_pkg.sv
hdl/tpc_ram.sv
hdl/tpc_queue.sv
hdl/tpc_front.sv
hdl/tpc_back.sv
hdl/two_phase_commit_coordinator.sv
dv/two_phase_commit_coordinator_tb.sv
